@@ rtl/core/laplacian_flux_stencil_top_defines.svh @@
// Assertion macros shared by the laplacian flux stencil checker.
// No dependencies; included by files that assert.
`ifndef LAPLACIAN_FLUX_STENCIL_TOP_DEFINES_SVH
`define LAPLACIAN_FLUX_STENCIL_TOP_DEFINES_SVH

// Check a property on i_clk, off while reset is held.
`define LFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on i_clk, also during reset.
`define LFS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/lfs_pkg.sv @@
// Types, sizes and saturation helper for the laplacian flux stencil.
// No dependencies; imported by lfs_window, lfs_lap, lfs_flux and the top level.
package lfs_pkg;

    localparam int NROWS  = 5;
    localparam int NHELD  = 4;
    localparam int DW     = 32;
    localparam int LW     = DW + 4;
    localparam int FILL_W = 3;

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(NHELD);

    typedef logic [DW-1:0] t_word;
    typedef t_word [NROWS-1:0] t_col;
    typedef t_col [NHELD-1:0] t_win;
    typedef t_col [NHELD:0] t_span;

    typedef struct packed {
        t_word ctr;
        t_word west;
        t_word east;
        t_word north;
        t_word south;
    } t_lap_set;

    localparam logic signed [LW-1:0] SAT_MAX = LW'({1'b0, {(DW-1){1'b1}}});
    localparam logic signed [LW-1:0] SAT_MIN = -SAT_MAX - LW'(1);

    function automatic t_word sat_word(logic signed [LW-1:0] v);
        t_word res;
        if (v > SAT_MAX) begin
            res = {1'b0, {(DW-1){1'b1}}};
        end else if (v < SAT_MIN) begin
            res = {1'b1, {(DW-1){1'b0}}};
        end else begin
            res = v[DW-1:0];
        end
        return res;
    endfunction

endpackage

@@ rtl/core/lfs_window.sv @@
// Column shift register holding the last four columns of a band row.
// Depends on lfs_pkg.
module lfs_window import lfs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  logic i_row_start,
    input  t_col i_col,
    output t_win o_win,
    output logic o_full
);

    t_win              r_win, n_win;
    logic [FILL_W-1:0] r_fill, n_fill;

    always_comb begin
        n_win  = r_win;
        n_fill = r_fill;
        if (i_shift) begin
            n_win = {i_col, r_win[NHELD-1:1]};
            if (i_row_start) begin
                n_fill = FILL_W'(1);
            end else if (r_fill != FILL_FULL) begin
                n_fill = r_fill + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    assign o_win  = r_win;
    assign o_full = (r_fill == FILL_FULL);

endmodule

@@ rtl/core/lfs_lap.sv @@
// Five-point Laplacian of one grid point, saturated to 32 bits.
// Depends on lfs_pkg.
module lfs_lap import lfs_pkg::*; (
    input  t_word i_ctr,
    input  t_word i_west,
    input  t_word i_east,
    input  t_word i_north,
    input  t_word i_south,
    output t_word o_lap
);

    logic signed [LW-1:0] ctr_x, west_x, east_x, north_x, south_x, sum;

    assign ctr_x   = LW'($signed(i_ctr));
    assign west_x  = LW'($signed(i_west));
    assign east_x  = LW'($signed(i_east));
    assign north_x = LW'($signed(i_north));
    assign south_x = LW'($signed(i_south));
    assign sum     = (ctr_x <<< 2) - west_x - east_x - north_x - south_x;
    assign o_lap   = sat_word(sum);

endmodule

@@ rtl/core/lfs_flux.sv @@
// Output stage: flux differences into the result register with handshake.
// Depends on lfs_pkg.
module lfs_flux import lfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  t_lap_set          i_laps,
    input  logic              i_stall,
    output logic              o_free,
    output logic              o_valid,
    output logic signed [31:0] o_west,
    output logic signed [31:0] o_east,
    output logic signed [31:0] o_north,
    output logic signed [31:0] o_south
);

    logic  r_vld;
    t_word r_west, r_east, r_north, r_south;
    logic  load;

    assign o_free = !r_vld || !i_stall;
    assign load   = o_free && i_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_west  <= i_laps.ctr - i_laps.west;
            r_east  <= i_laps.east - i_laps.ctr;
            r_north <= i_laps.ctr - i_laps.north;
            r_south <= i_laps.south - i_laps.ctr;
        end
    end

    assign o_valid = r_vld;
    assign o_west  = $signed(r_west);
    assign o_east  = $signed(r_east);
    assign o_north = $signed(r_north);
    assign o_south = $signed(r_south);

endmodule

@@ rtl/core/laplacian_flux_stencil_top.sv @@
// Laplacian flux stencil: an accepted column passes the Laplacian register, then the flux result register.
// Throughput one column per cycle while o_in_stall is low; results start once four columns of a row are held.
// Stages: column window and Laplacians -> Laplacian register -> flux result register.
// Synchronous active-low reset empties the pipeline and the window fill count.
// Depends on lfs_pkg, lfs_window, lfs_lap, lfs_flux.
module laplacian_flux_stencil_top import lfs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_row_start,
    input  logic signed [31:0] i_sample_row0,
    input  logic signed [31:0] i_sample_row1,
    input  logic signed [31:0] i_sample_row2,
    input  logic signed [31:0] i_sample_row3,
    input  logic signed [31:0] i_sample_row4,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_flux_west,
    output logic signed [31:0] o_flux_east,
    output logic signed [31:0] o_flux_north,
    output logic signed [31:0] o_flux_south
);

    t_col     in_col;
    t_win     held;
    t_span    w;
    logic     full;
    logic     accept;
    logic     produce;
    logic     out_free;
    logic     mid_free;
    t_lap_set laps;
    logic     r_mid_vld;
    t_lap_set r_mid;

    assign in_col = {i_sample_row4, i_sample_row3, i_sample_row2,
                     i_sample_row1, i_sample_row0};

    assign mid_free   = !r_mid_vld || out_free;
    assign o_in_stall = !mid_free;
    assign accept     = i_in_valid && mid_free;
    assign produce    = full && !i_row_start;

    lfs_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_shift     (accept),
        .i_row_start (i_row_start),
        .i_col       (in_col),
        .o_win       (held),
        .o_full      (full)
    );

    assign w = {in_col, held};

    lfs_lap u_lap_ctr (
        .i_ctr (w[2][2]), .i_west (w[1][2]), .i_east (w[3][2]),
        .i_north (w[2][1]), .i_south (w[2][3]), .o_lap (laps.ctr)
    );

    lfs_lap u_lap_west (
        .i_ctr (w[1][2]), .i_west (w[0][2]), .i_east (w[2][2]),
        .i_north (w[1][1]), .i_south (w[1][3]), .o_lap (laps.west)
    );

    lfs_lap u_lap_east (
        .i_ctr (w[3][2]), .i_west (w[2][2]), .i_east (w[4][2]),
        .i_north (w[3][1]), .i_south (w[3][3]), .o_lap (laps.east)
    );

    lfs_lap u_lap_north (
        .i_ctr (w[2][1]), .i_west (w[1][1]), .i_east (w[3][1]),
        .i_north (w[2][0]), .i_south (w[2][2]), .o_lap (laps.north)
    );

    lfs_lap u_lap_south (
        .i_ctr (w[2][3]), .i_west (w[1][3]), .i_east (w[3][3]),
        .i_north (w[2][2]), .i_south (w[2][4]), .o_lap (laps.south)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_vld <= 1'b0;
        end else if (mid_free) begin
            r_mid_vld <= accept && produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && produce) begin
            r_mid <= laps;
        end
    end

    lfs_flux u_flux (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_mid_vld),
        .i_laps  (r_mid),
        .i_stall (i_out_stall),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_west  (o_flux_west),
        .o_east  (o_flux_east),
        .o_north (o_flux_north),
        .o_south (o_flux_south)
    );

endmodule

@@ rtl/core/lfs_checker.sv @@
// Port-level checks for the laplacian flux stencil, bound to the top level.
// Depends on laplacian_flux_stencil_top_defines.svh and laplacian_flux_stencil_top.
`include "laplacian_flux_stencil_top_defines.svh"

module lfs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_flux_west,
    input logic signed [31:0] o_flux_south
);

    `LFS_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid, "result word dropped while stalled")
    `LFS_ASSERT(a_out_stable, o_out_valid && i_out_stall |=> $stable(o_flux_west) && $stable(o_flux_south), "stalled result word changed")
    `LFS_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `LFS_ASSERT(a_no_false_stall, !o_out_valid || !i_out_stall |-> !o_in_stall, "input stalled with free result stage")

endmodule

bind laplacian_flux_stencil_top lfs_checker u_lfs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_flux_west  (o_flux_west),
    .o_flux_south (o_flux_south)
);

@@ tb/testbench.sv @@
// Self-checking testbench for laplacian_flux_stencil_top: streams five-row columns
// and compares each flux word with an in-bench Laplacian flux predictor.
// Depends on lfs_pkg (row count, held column count, word width) and the stencil RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lfs_pkg::NROWS;
    import lfs_pkg::NHELD;
    import lfs_pkg::DW;

    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_COLUMNS = 1900;
    localparam int SETTLE_CYCLES = 8;
    localparam logic signed [DW-1:0] WORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [DW-1:0] WORD_MIN = 32'sh8000_0000;

    typedef logic [NROWS-1:0][DW-1:0] t_column;

    typedef struct packed {
        logic signed [DW-1:0] west;
        logic signed [DW-1:0] east;
        logic signed [DW-1:0] north;
        logic signed [DW-1:0] south;
    } t_flux_set;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_row_start;
    logic signed [31:0] i_sample_row0;
    logic signed [31:0] i_sample_row1;
    logic signed [31:0] i_sample_row2;
    logic signed [31:0] i_sample_row3;
    logic signed [31:0] i_sample_row4;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_flux_west;
    logic signed [31:0] o_flux_east;
    logic signed [31:0] o_flux_north;
    logic signed [31:0] o_flux_south;

    t_flux_set pending_flux[$];
    t_column   held_cols [NHELD];
    int        held_count;
    int        fail_count;
    int        stall_left;
    bit        stall_on;
    bit        gaps_on;

    laplacian_flux_stencil_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_row_start  (i_row_start),
        .i_sample_row0(i_sample_row0),
        .i_sample_row1(i_sample_row1),
        .i_sample_row2(i_sample_row2),
        .i_sample_row3(i_sample_row3),
        .i_sample_row4(i_sample_row4),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_flux_west  (o_flux_west),
        .o_flux_east  (o_flux_east),
        .o_flux_north (o_flux_north),
        .o_flux_south (o_flux_south)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [DW-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return -32'sd1;
            4, 5: return 32'(int'($urandom_range(0, 200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_column rand_column();
        t_column col;
        for (int r = 0; r < NROWS; r++) begin
            col[r] = rand_sample();
        end
        return col;
    endfunction

    function automatic t_column uniform_column(logic signed [DW-1:0] v);
        t_column col;
        for (int r = 0; r < NROWS; r++) begin
            col[r] = v;
        end
        return col;
    endfunction

    function automatic logic signed [DW-1:0] sat_laplace(longint p, longint l, longint r,
                                                         longint u, longint d);
        longint v;
        v = 4 * p - l - r - u - d;
        if (v > longint'(WORD_MAX)) begin
            return WORD_MAX;
        end else if (v < longint'(WORD_MIN)) begin
            return WORD_MIN;
        end
        return v[DW-1:0];
    endfunction

    task automatic predict_flux(input logic row_start, input t_column col);
        longint               w [5][NROWS];
        logic signed [DW-1:0] lc, ll, lr, lu, ld;
        t_flux_set            f;
        if (row_start) begin
            held_count = 0;
        end
        if (held_count >= NHELD) begin
            for (int c = 0; c < 5; c++) begin
                for (int r = 0; r < NROWS; r++) begin
                    w[c][r] = (c < NHELD) ? longint'($signed(held_cols[c][r]))
                                          : longint'($signed(col[r]));
                end
            end
            lc = sat_laplace(w[2][2], w[1][2], w[3][2], w[2][1], w[2][3]);
            ll = sat_laplace(w[1][2], w[0][2], w[2][2], w[1][1], w[1][3]);
            lr = sat_laplace(w[3][2], w[2][2], w[4][2], w[3][1], w[3][3]);
            lu = sat_laplace(w[2][1], w[1][1], w[3][1], w[2][0], w[2][2]);
            ld = sat_laplace(w[2][3], w[1][3], w[3][3], w[2][2], w[2][4]);
            f.west  = lc - ll;
            f.east  = lr - lc;
            f.north = lc - lu;
            f.south = ld - lc;
            pending_flux.push_back(f);
            for (int c = 0; c < NHELD - 1; c++) begin
                held_cols[c] = held_cols[c+1];
            end
            held_cols[NHELD-1] = col;
        end else begin
            held_cols[held_count] = col;
            held_count++;
        end
    endtask

    task automatic send_column(input logic row_start, input t_column col);
        i_in_valid    <= 1'b1;
        i_row_start   <= row_start;
        i_sample_row0 <= col[0];
        i_sample_row1 <= col[1];
        i_sample_row2 <= col[2];
        i_sample_row3 <= col[3];
        i_sample_row4 <= col[4];
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        predict_flux(row_start, col);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            idle_input(gap_len());
        end
    endtask

    task automatic idle_input(input int cycles);
        i_in_valid    <= 1'b0;
        i_row_start   <= 1'($urandom_range(0, 1));
        i_sample_row0 <= $urandom;
        i_sample_row1 <= $urandom;
        i_sample_row2 <= $urandom;
        i_sample_row3 <= $urandom;
        i_sample_row4 <= $urandom;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [DW-1:0] want,
                               input logic [DW-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d actual %0d", name, $signed(want), $signed(got));
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_flux
        t_flux_set want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_flux.size() == 0) begin
                $error("flux word with no expected value pending");
                fail_count++;
            end else begin
                want = pending_flux.pop_front();
                check_field("flux_west", want.west, o_flux_west);
                check_field("flux_east", want.east, o_flux_east);
                check_field("flux_north", want.north, o_flux_north);
                check_field("flux_south", want.south, o_flux_south);
            end
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (stall_on && $urandom_range(0, 3) == 0) begin
                stall_left = gap_len();
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic test_fill_after_reset();
        for (int k = 0; k < 5; k++) begin
            send_column(1'b0, uniform_column(WORD_MAX));
        end
        send_column(1'b0, uniform_column('0));
    endtask

    task automatic test_uniform_extremes();
        send_column(1'b1, uniform_column(WORD_MIN));
        for (int k = 0; k < 4; k++) begin
            send_column(1'b0, uniform_column(WORD_MIN));
        end
    endtask

    task automatic test_laplacian_saturation();
        t_column col;
        for (int c = 0; c < 6; c++) begin
            for (int r = 0; r < NROWS; r++) begin
                col[r] = ((c + r) % 2 == 0) ? WORD_MAX : WORD_MIN;
            end
            send_column(c == 0, col);
        end
    endtask

    task automatic test_row_restart();
        stall_on = 1'b1;
        gaps_on  = 1'b1;
        send_column(1'b1, rand_column());
        send_column(1'b0, rand_column());
        send_column(1'b0, rand_column());
        send_column(1'b1, rand_column());
        for (int k = 0; k < 4; k++) begin
            send_column(1'b0, rand_column());
        end
    endtask

    task automatic test_random_rows();
        int sent;
        int len;
        sent = 0;
        while (sent < RANDOM_COLUMNS) begin
            gaps_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: begin
                    len = $urandom_range(1, 4);
                    for (int k = 0; k < len; k++) begin
                        send_column(1'($urandom_range(0, 1)), rand_column());
                    end
                end
                1: begin
                    len = $urandom_range(1, 4);
                    for (int k = 0; k < len; k++) begin
                        send_column(k == 0, rand_column());
                    end
                end
                default: begin
                    len = $urandom_range(5, 40);
                    for (int k = 0; k < len; k++) begin
                        send_column(k == 0, rand_column());
                    end
                end
            endcase
            sent += len;
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_row_start   <= 1'b0;
        i_sample_row0 <= '0;
        i_sample_row1 <= '0;
        i_sample_row2 <= '0;
        i_sample_row3 <= '0;
        i_sample_row4 <= '0;
        i_out_stall   <= 1'b0;
        stall_left    = 0;
        stall_on      = 1'b0;
        gaps_on       = 1'b0;
        held_count    = 0;
        fail_count    = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_after_reset();
        test_uniform_extremes();
        test_laplacian_saturation();
        test_row_restart();
        test_random_rows();

        i_in_valid <= 1'b0;
        while (pending_flux.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_flux.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
